// File: rtl/pcs_pkg.sv
// Shared types and fixed constants of the Pearson correlation stream.
// Used by pcs_engine and pearson_correlation_stream; no dependencies.
package pcs_pkg;

    // Fixed field widths of the sample and result ports
    localparam int IN_W    = 24;
    localparam int CORR_W  = 32;

    // Result format: signed Q1.30, magnitude search over QW bits
    localparam int Q_FRAC  = 30;
    localparam int QW      = Q_FRAC + 1;
    localparam int KW      = $clog2(QW);

    // Scaling of the squared covariance and of the first search term
    localparam int R_SHIFT = 2 * Q_FRAC + 2;
    localparam int ES_SHIFT = Q_FRAC + 2;

    // Headroom above the product of the two spreads during the search
    localparam int SEARCH_GUARD = 2 * QW + 4;

    // Full-scale correlation (+1.0)
    localparam logic signed [CORR_W-1:0] CORR_ONE = CORR_W'(1) <<< Q_FRAC;

    // Top-level sequencer: accumulate one pair, then finalize on the last one
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YY,
        ST_XY,
        ST_START,
        ST_WAIT
    } t_pcs_state;

    // Finalize engine phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_A1,
        PH_A2,
        PH_B1,
        PH_B2,
        PH_C1,
        PH_C2,
        PH_ABS,
        PH_MM,
        PH_PP,
        PH_NEG,
        PH_SUM,
        PH_TRY,
        PH_UPD,
        PH_DONE
    } t_pcs_phase;

endpackage

// File: rtl/pcs_engine.sv
// Finalize engine: spreads, covariance and the rounded Q1.30 correlation.
// One shared wide adder does shift-add products and a bitwise root search.
// Depends on pcs_pkg.
module pcs_engine
    import pcs_pkg::*;
#(
    parameter int MAX_SAMPLES = 128,
    parameter int SAMPLE_BITS = 24,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
    localparam int LOG_N = $clog2(MAX_SAMPLES),
    localparam int SUM_W = SAMPLE_BITS + LOG_N,
    localparam int SQ_W  = 2 * SAMPLE_BITS + LOG_N
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [SUM_W-1:0]         i_sum_x,
    input  logic [SUM_W-1:0]         i_sum_y,
    input  logic [SQ_W-1:0]          i_sum_xx,
    input  logic [SQ_W-1:0]          i_sum_yy,
    input  logic [SQ_W-1:0]          i_sum_xy,
    output logic                     o_done,
    output logic signed [CORR_W-1:0] o_correlation,
    output logic                     o_degenerate
);

    // Spread width and full width of the shared adder
    localparam int SP_W = CNT_W + SQ_W;
    localparam int W    = 2 * SP_W + SEARCH_GUARD;

    t_pcs_phase r_phase, n_phase;

    logic [W-1:0]    r_acc,    n_acc;
    logic [W-1:0]    r_mcand,  n_mcand;
    logic [SP_W-1:0] r_mplier, n_mplier;
    logic [W-1:0]    r_tmp,    n_tmp;
    logic [SP_W-1:0] r_vx,     n_vx;
    logic [SP_W-1:0] r_vy,     n_vy;
    logic            r_neg,    n_neg;
    logic            r_degen,  n_degen;
    logic [W-1:0]    r_d,      n_d;
    logic [W-1:0]    r_es,     n_es;
    logic [W-1:0]    r_ps,     n_ps;
    logic [QW-1:0]   r_q,      n_q;
    logic [KW-1:0]   r_k,      n_k;

    // Shared adder / subtractor
    logic [W-1:0] add_a, add_b, add_sum;
    logic         add_sub;

    logic mul_phase, mul_run, diff_bad, last_bit;
    logic [SP_W-1:0] mag;
    logic [CORR_W-1:0] q_ext;

    assign add_sum = add_a + (add_b ^ {W{add_sub}}) + {{(W-1){1'b0}}, add_sub};

    assign mul_run   = (r_mplier != '0);
    assign mul_phase = (r_phase == PH_A1) || (r_phase == PH_A2) || (r_phase == PH_B1) ||
                       (r_phase == PH_B2) || (r_phase == PH_C1) || (r_phase == PH_C2) ||
                       (r_phase == PH_MM) || (r_phase == PH_PP);
    assign diff_bad  = add_sum[W-1] || (add_sum == '0);
    assign last_bit  = (r_k == '0);
    assign mag       = add_sum[SP_W-1:0];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_start) n_phase = PH_A1;
            PH_A1:   if (!mul_run) n_phase = PH_A2;
            PH_A2:   if (!mul_run) n_phase = diff_bad ? PH_DONE : PH_B1;
            PH_B1:   if (!mul_run) n_phase = PH_B2;
            PH_B2:   if (!mul_run) n_phase = diff_bad ? PH_DONE : PH_C1;
            PH_C1:   if (!mul_run) n_phase = PH_C2;
            PH_C2:   if (!mul_run) n_phase = PH_ABS;
            PH_ABS:  n_phase = PH_MM;
            PH_MM:   if (!mul_run) n_phase = PH_PP;
            PH_PP:   if (!mul_run) n_phase = PH_NEG;
            PH_NEG:  n_phase = PH_SUM;
            PH_SUM:  n_phase = PH_TRY;
            PH_TRY: begin
                if (!add_sum[W-1]) n_phase = PH_UPD;
                else if (last_bit) n_phase = PH_DONE;
                else               n_phase = PH_SUM;
            end
            PH_UPD:  n_phase = last_bit ? PH_DONE : PH_SUM;
            PH_DONE: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    // Datapath control: adder operands and register updates
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_tmp    = r_tmp;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_neg    = r_neg;
        n_degen  = r_degen;
        n_d      = r_d;
        n_es     = r_es;
        n_ps     = r_ps;
        n_q      = r_q;
        n_k      = r_k;
        add_a    = '0;
        add_b    = '0;
        add_sub  = 1'b0;

        if (mul_phase && mul_run) begin
            // One shift-add step of the running product
            add_a    = r_acc;
            add_b    = r_mplier[0] ? r_mcand : '0;
            n_acc    = add_sum;
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        n_acc    = '0;
                        n_mcand  = W'(i_sum_xx);
                        n_mplier = SP_W'(i_count);
                        n_degen  = 1'b0;
                    end
                end
                PH_A1: begin
                    n_tmp    = r_acc;
                    n_acc    = '0;
                    n_mcand  = W'(i_sum_x);
                    n_mplier = SP_W'(i_sum_x);
                end
                PH_A2: begin
                    // Spread of x; flag it when not positive
                    add_a    = r_tmp;
                    add_b    = r_acc;
                    add_sub  = 1'b1;
                    n_vx     = mag;
                    n_degen  = diff_bad;
                    n_acc    = '0;
                    n_mcand  = W'(i_sum_yy);
                    n_mplier = SP_W'(i_count);
                end
                PH_B1: begin
                    n_tmp    = r_acc;
                    n_acc    = '0;
                    n_mcand  = W'(i_sum_y);
                    n_mplier = SP_W'(i_sum_y);
                end
                PH_B2: begin
                    add_a    = r_tmp;
                    add_b    = r_acc;
                    add_sub  = 1'b1;
                    n_vy     = mag;
                    n_degen  = diff_bad;
                    n_acc    = '0;
                    n_mcand  = W'(i_sum_xy);
                    n_mplier = SP_W'(i_count);
                end
                PH_C1: begin
                    n_tmp    = r_acc;
                    n_acc    = '0;
                    n_mcand  = W'(i_sum_x);
                    n_mplier = SP_W'(i_sum_y);
                end
                PH_C2: begin
                    // Sign of the covariance
                    add_a    = r_tmp;
                    add_b    = r_acc;
                    add_sub  = 1'b1;
                    n_neg    = add_sum[W-1];
                end
                PH_ABS: begin
                    // Covariance magnitude, then square it
                    add_a    = r_neg ? r_acc : r_tmp;
                    add_b    = r_neg ? r_tmp : r_acc;
                    add_sub  = 1'b1;
                    n_acc    = '0;
                    n_mcand  = W'(mag);
                    n_mplier = mag;
                end
                PH_MM: begin
                    n_d      = r_acc << R_SHIFT;
                    n_acc    = '0;
                    n_mcand  = W'(r_vx);
                    n_mplier = r_vy;
                end
                PH_PP: begin
                    // Search residue for t = -1, and the first square term
                    add_a    = r_d;
                    add_b    = r_acc;
                    add_sub  = 1'b1;
                    n_d      = add_sum;
                    n_ps     = r_acc << R_SHIFT;
                end
                PH_NEG: begin
                    add_a    = '0;
                    add_b    = r_acc << ES_SHIFT;
                    add_sub  = 1'b1;
                    n_es     = add_sum;
                    n_k      = KW'(QW - 1);
                    n_q      = '0;
                end
                PH_SUM: begin
                    add_a    = r_es;
                    add_b    = r_ps;
                    n_tmp    = add_sum;
                end
                PH_TRY: begin
                    // Keep the bit when the residue stays non-negative
                    add_a    = r_d;
                    add_b    = r_tmp;
                    add_sub  = 1'b1;
                    n_q      = {r_q[QW-2:0], ~add_sum[W-1]};
                    if (!add_sum[W-1]) begin
                        n_d  = add_sum;
                    end else begin
                        n_es = {r_es[W-1], r_es[W-1:1]};
                        n_ps = r_ps >> 2;
                        n_k  = r_k - KW'(1);
                    end
                end
                PH_UPD: begin
                    add_a    = r_es;
                    add_b    = r_ps << 1;
                    n_es     = {add_sum[W-1], add_sum[W-1:1]};
                    n_ps     = r_ps >> 2;
                    n_k      = r_k - KW'(1);
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result outputs
    always_comb begin
        q_ext         = CORR_W'(r_q);
        o_done        = (r_phase == PH_DONE);
        o_degenerate  = r_degen;
        if (r_degen)    o_correlation = '0;
        else if (r_neg) o_correlation = -$signed(q_ext);
        else            o_correlation = $signed(q_ext);
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_tmp    <= n_tmp;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_neg    <= n_neg;
        r_degen  <= n_degen;
        r_d      <= n_d;
        r_es     <= n_es;
        r_ps     <= n_ps;
        r_q      <= n_q;
        r_k      <= n_k;
    end

    // Checks
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("engine done held for more than one cycle");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_degenerate) |->
            (o_correlation <= CORR_ONE) && (o_correlation >= -CORR_ONE))
        else $error("correlation outside [-1, 1]");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_correlation == '0))
        else $error("degenerate result is not zero");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_phase == PH_IDLE))
        else $error("engine started while busy");

endmodule

// File: rtl/pearson_correlation_stream.sv
// Streaming Pearson correlation: pair accumulation and result sequencing.
// Instantiates pcs_engine; depends on pcs_pkg.
//
// Usage: drive i_x_sample, i_y_sample and i_last_sample and raise start; the
// pair transfers at a rising edge where start is high and busy is low. Each
// pair adds into exact sums of x, y, x*x, y*y and x*y through one
// SAMPLE_BITS x SAMPLE_BITS multiplier that is used once per cycle, so after
// its transfer a pair keeps busy high through the ST_YY and ST_XY states.
// Samples above 2^SAMPLE_BITS - 1 clamp to that value; pairs past the first
// MAX_SAMPLES of a profile are dropped from the sums.
// A pair with i_last_sample set starts the finalize engine, whose single
// wide adder runs eight shift-add products (one multiplier bit per cycle,
// ending once the remaining multiplier bits are zero) and a 31-step bitwise
// search of the rounded Q1.30 result. A degenerate profile finishes early.
// The result is valid on o_correlation / o_degenerate while o_done is high
// for a single cycle; the receiver cannot stall it. The sums then clear and
// busy drops. Reset (synchronous, active low) clears the sums and the
// sequencers.
module pearson_correlation_stream
    import pcs_pkg::*;
#(
    parameter int MAX_SAMPLES = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [IN_W-1:0]          i_x_sample,
    input  logic [IN_W-1:0]          i_y_sample,
    input  logic                     i_last_sample,
    output logic                     o_done,
    output logic signed [CORR_W-1:0] o_correlation,
    output logic                     o_degenerate
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N = $clog2(MAX_SAMPLES);
    localparam int SUM_W = SAMPLE_BITS + LOG_N;
    localparam int SQ_W  = 2 * SAMPLE_BITS + LOG_N;
    localparam logic [IN_W-1:0] SMAX = IN_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    t_pcs_state r_state, n_state;

    logic [CNT_W-1:0]       r_count,  n_count;
    logic [SUM_W-1:0]       r_sum_x,  n_sum_x;
    logic [SUM_W-1:0]       r_sum_y,  n_sum_y;
    logic [SQ_W-1:0]        r_sum_xx, n_sum_xx;
    logic [SQ_W-1:0]        r_sum_yy, n_sum_yy;
    logic [SQ_W-1:0]        r_sum_xy, n_sum_xy;
    logic [SAMPLE_BITS-1:0] r_x, n_x;
    logic [SAMPLE_BITS-1:0] r_y, n_y;
    logic                   r_last, n_last;
    logic                   r_take, n_take;

    logic [SAMPLE_BITS-1:0]   clamp_x, clamp_y;
    logic [SAMPLE_BITS-1:0]   mul_a, mul_b;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic                     eng_start, eng_done;

    // Clamp incoming samples
    assign clamp_x = (i_x_sample > SMAX) ? SMAX[SAMPLE_BITS-1:0] : i_x_sample[SAMPLE_BITS-1:0];
    assign clamp_y = (i_y_sample > SMAX) ? SMAX[SAMPLE_BITS-1:0] : i_y_sample[SAMPLE_BITS-1:0];

    assign prod = mul_a * mul_b;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_YY;
            ST_YY:    n_state = ST_XY;
            ST_XY:    n_state = r_last ? ST_START : ST_IDLE;
            ST_START: n_state = ST_WAIT;
            ST_WAIT:  if (eng_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Accumulation and handshake outputs
    always_comb begin
        n_count   = r_count;
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_sum_xx  = r_sum_xx;
        n_sum_yy  = r_sum_yy;
        n_sum_xy  = r_sum_xy;
        n_x       = r_x;
        n_y       = r_y;
        n_last    = r_last;
        n_take    = r_take;
        mul_a     = r_x;
        mul_b     = r_y;
        busy      = (r_state != ST_IDLE);
        eng_start = (r_state == ST_START);

        unique case (r_state)
            ST_IDLE: begin
                // Transfer a pair; add it unless the profile is full
                mul_a = clamp_x;
                mul_b = clamp_x;
                if (start) begin
                    n_x    = clamp_x;
                    n_y    = clamp_y;
                    n_last = i_last_sample;
                    n_take = (r_count < CNT_W'(MAX_SAMPLES));
                    if (r_count < CNT_W'(MAX_SAMPLES)) begin
                        n_count  = r_count + CNT_W'(1);
                        n_sum_x  = r_sum_x + SUM_W'(clamp_x);
                        n_sum_y  = r_sum_y + SUM_W'(clamp_y);
                        n_sum_xx = r_sum_xx + SQ_W'(prod);
                    end
                end
            end
            ST_YY: begin
                mul_a = r_y;
                mul_b = r_y;
                if (r_take) n_sum_yy = r_sum_yy + SQ_W'(prod);
            end
            ST_XY: begin
                if (r_take) n_sum_xy = r_sum_xy + SQ_W'(prod);
            end
            ST_START: begin
            end
            ST_WAIT: begin
                // Drop the profile once its result transfers
                if (eng_done) begin
                    n_count  = '0;
                    n_sum_x  = '0;
                    n_sum_y  = '0;
                    n_sum_xx = '0;
                    n_sum_yy = '0;
                    n_sum_xy = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_yy <= '0;
            r_sum_xy <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_sum_xx <= n_sum_xx;
            r_sum_yy <= n_sum_yy;
            r_sum_xy <= n_sum_xy;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_last <= n_last;
        r_take <= n_take;
    end

    // Finalize engine
    pcs_engine #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (eng_start),
        .i_count       (r_count),
        .i_sum_x       (r_sum_x),
        .i_sum_y       (r_sum_y),
        .i_sum_xx      (r_sum_xx),
        .i_sum_yy      (r_sum_yy),
        .i_sum_xy      (r_sum_xy),
        .o_done        (eng_done),
        .o_correlation (o_correlation),
        .o_degenerate  (o_degenerate)
    );

    assign o_done = eng_done;

    // Checks
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == ST_WAIT))
        else $error("result transfer outside the wait state");

    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_count == '0) && (r_sum_x == '0) && (r_sum_xy == '0))
        else $error("sums not cleared after a result");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("pair count above its limit");

endmodule

// File: tb/testbench.sv
// Self-checking bench for pearson_correlation_stream: directed and random profiles.
// Depends on pcs_pkg and the RTL; holds its own exact-integer correlation tracker.

module testbench;
    localparam int PAIR_LIMIT   = 128;
    localparam int SAMPLE_BITS  = 24;
    localparam int ITEM_TARGET  = 550;
    localparam int IDLE_PCT     = 26;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [pcs_pkg::IN_W-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic signed [pcs_pkg::CORR_W-1:0] corr;
        logic                              degen;
    } t_corr_result;

    typedef enum int {
        GEN_RANDOM,
        GEN_SMALL,
        GEN_HIGH,
        GEN_TRACK,
        GEN_MIRROR,
        GEN_FLAT_X,
        GEN_FLAT_Y
    } t_gen_mode;

    // Keeps running sums of the open profile and the correlations still owed by the block
    class correlation_tracker;
        localparam logic [63:0] SAMPLE_CLAMP = (64'd1 << SAMPLE_BITS) - 64'd1;

        int unsigned  pair_cnt;
        logic [63:0]  sum_x, sum_y, sum_xx, sum_yy, sum_xy;
        t_corr_result expected_corr[$];
        int           errors;
        int           checked;
        int           degenerate_seen;

        function new();
            clear_sums();
            errors = 0;
            checked = 0;
            degenerate_seen = 0;
        endfunction

        function void clear_sums();
            pair_cnt = 0;
            sum_x = '0;
            sum_y = '0;
            sum_xx = '0;
            sum_yy = '0;
            sum_xy = '0;
        endfunction

        // n * sum of squares - sum squared, floored at zero
        function logic [255:0] spread(logic [63:0] n, logic [63:0] s1, logic [63:0] s2);
            logic [255:0] a;
            logic [255:0] b;
            a = 256'(n) * 256'(s2);
            b = 256'(s1) * 256'(s1);
            return (a > b) ? a - b : 256'd0;
        endfunction

        // Add one transferred pair; on the last pair queue the correlation it owes
        function void note_pair(logic [23:0] x_raw, logic [23:0] y_raw, logic last);
            logic [63:0]  x, y, lo, hi, mid;
            logic [255:0] sxx, syy, a, b, mag, prod, rhs, lhs, t;
            logic         neg;
            t_corr_result r;
            x = 64'(x_raw);
            y = 64'(y_raw);
            if (x > SAMPLE_CLAMP) x = SAMPLE_CLAMP;
            if (y > SAMPLE_CLAMP) y = SAMPLE_CLAMP;
            // drop pairs past the profile limit from the sums
            if (pair_cnt < PAIR_LIMIT) begin
                pair_cnt++;
                sum_x += x;
                sum_y += y;
                sum_xx += x * x;
                sum_yy += y * y;
                sum_xy += x * y;
            end
            if (!last) return;

            sxx = spread(64'(pair_cnt), sum_x, sum_xx);
            syy = spread(64'(pair_cnt), sum_y, sum_yy);
            if (sxx == 0 || syy == 0) begin
                r.corr = '0;
                r.degen = 1'b1;
            end else begin
                a = 256'(pair_cnt) * 256'(sum_xy);
                b = 256'(sum_x) * 256'(sum_y);
                neg = (a < b);
                mag = neg ? b - a : a - b;
                prod = sxx * syy;
                rhs = (mag * mag) << (2 * pcs_pkg::Q_FRAC + 2);
                // largest q with (2q-1)^2 * Sxx * Syy <= 2^62 * Sxy^2: round to nearest
                lo = '0;
                hi = 64'd1 << pcs_pkg::Q_FRAC;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 64'd1) / 64'd2;
                    t = 256'(2 * mid - 64'd1);
                    lhs = t * t * prod;
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 64'd1;
                end
                r.corr = lo[pcs_pkg::CORR_W-1:0];
                if (neg) r.corr = -r.corr;
                r.degen = 1'b0;
            end
            expected_corr = {expected_corr, r};
            clear_sums();
        endfunction

        // Compare one strobed result with the oldest owed correlation
        function void check_result(logic signed [pcs_pkg::CORR_W-1:0] corr, logic degen);
            t_corr_result want;
            if (expected_corr.size() == 0) begin
                $error("unexpected result: correlation %0d degenerate %0b", corr, degen);
                errors++;
                return;
            end
            want = expected_corr.pop_front();
            checked++;
            if (want.degen) degenerate_seen++;
            if (corr !== want.corr) begin
                $error("correlation mismatch: expected %0d, got %0d", want.corr, corr);
                errors++;
            end
            if (degen !== want.degen) begin
                $error("degenerate mismatch: expected %0b, got %0b", want.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [pcs_pkg::IN_W-1:0]          x_sample;
    logic [pcs_pkg::IN_W-1:0]          y_sample;
    logic                              last_sample;
    logic                              done;
    logic signed [pcs_pkg::CORR_W-1:0] correlation;
    logic                              degenerate;

    correlation_tracker tracker = new();

    logic steady;
    int   pairs_sent;
    int   profile_len;
    int   longest_profile;

    pearson_correlation_stream #(
        .MAX_SAMPLES (PAIR_LIMIT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_sample    (x_sample),
        .i_y_sample    (y_sample),
        .i_last_sample (last_sample),
        .o_done        (done),
        .o_correlation (correlation),
        .o_degenerate  (degenerate)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Observe transfers and results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (done) tracker.check_result(correlation, degenerate);
            if (start && !busy) begin
                tracker.note_pair(x_sample, y_sample, last_sample);
                profile_len++;
                if (last_sample) begin
                    if (profile_len > longest_profile) longest_profile = profile_len;
                    profile_len = 0;
                end
            end
        end
    end

    // Offer one pair from a falling edge and hold it until it transfers
    task automatic send_pair(input logic [pcs_pkg::IN_W-1:0] x,
                             input logic [pcs_pkg::IN_W-1:0] y, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            start = 1'b0;
            x_sample = 24'($urandom);
            y_sample = 24'($urandom);
            last_sample = 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        start = 1'b1;
        x_sample = x;
        y_sample = y;
        last_sample = last;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed correlation has come back
    task automatic wait_drained();
        start = 1'b0;
        while (tracker.expected_corr.size() != 0) @(negedge i_clk);
    endtask

    // Send one profile of len pairs shaped by mode; the final pair carries last
    task automatic send_profile(input int len, input t_gen_mode mode);
        logic [pcs_pkg::IN_W-1:0] x, y, x0, y0, noise;
        int i;
        x0 = 24'($urandom);
        y0 = 24'($urandom);
        for (i = 0; i < len; i++) begin
            x = 24'($urandom);
            y = 24'($urandom);
            noise = 24'($urandom_range(0, 1023));
            unique case (mode)
                GEN_SMALL: begin
                    x = 24'($urandom_range(0, 255));
                    y = 24'($urandom_range(0, 255));
                end
                GEN_HIGH: begin
                    x = SAMPLE_MAX - 24'($urandom_range(0, 4095));
                    y = SAMPLE_MAX - 24'($urandom_range(0, 4095));
                end
                GEN_TRACK: y = (x > SAMPLE_MAX - noise) ? SAMPLE_MAX : x + noise;
                GEN_MIRROR: y = (SAMPLE_MAX - x) ^ (noise & 24'hFF);
                GEN_FLAT_X: x = x0;
                GEN_FLAT_Y: y = y0;
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial begin
        int directed_pairs;
        int profiles;
        int long_runs;
        int len;
        int pick;
        i_rst_n = 1'b0;
        start = 1'b0;
        x_sample = '0;
        y_sample = '0;
        last_sample = 1'b0;
        steady = 1'b0;
        pairs_sent = 0;
        profile_len = 0;
        longest_profile = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single pair, perfect positive and negative, flat x, flat y, four mixed pairs, all zero
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_pair('0, '0, 1'b0);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_pair('0, SAMPLE_MAX, 1'b0);
        send_pair(SAMPLE_MAX, '0, 1'b1);
        send_pair(24'd5, 24'd1, 1'b0);
        send_pair(24'd5, 24'd900, 1'b0);
        send_pair(24'd5, SAMPLE_MAX, 1'b1);
        send_pair('0, 24'd7, 1'b0);
        send_pair(24'd1234, 24'd7, 1'b0);
        send_pair(SAMPLE_MAX, 24'd7, 1'b1);
        send_pair(24'h123456, 24'h0F0F0F, 1'b0);
        send_pair(24'hABCDEF, 24'hF0F0F0, 1'b0);
        send_pair(24'h000001, 24'h800000, 1'b0);
        send_pair(24'h7FFFFF, 24'h000001, 1'b1);
        send_pair('0, '0, 1'b0);
        send_pair('0, '0, 1'b1);
        wait_drained();
        directed_pairs = pairs_sent;

        // random profiles: mostly short, a few past the pair limit
        profiles = 0;
        long_runs = 0;
        while (pairs_sent - directed_pairs < ITEM_TARGET) begin
            steady = (profiles >= 20 && profiles < 32);
            if (profiles == 26) wait_drained();
            pick = $urandom_range(0, 99);
            if (profiles == 4 || (long_runs < 2 && $urandom_range(0, 49) == 0)) begin
                len = $urandom_range(PAIR_LIMIT + 1, PAIR_LIMIT + 8);
                long_runs++;
            end else if (pick < 8) begin
                len = 1;
            end else if (pick < 18) begin
                len = 2;
            end else begin
                len = $urandom_range(3, 14);
            end
            send_profile(len, t_gen_mode'($urandom_range(0, GEN_FLAT_Y)));
            profiles++;
        end

        // let the last profile finish, then allow for a stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d pair transfers in %0d random and 7 directed profiles",
                 pairs_sent, profiles);
        $display("checked %0d correlations, %0d degenerate; longest profile %0d pairs",
                 tracker.checked, tracker.degenerate_seen, longest_profile);
        if (tracker.errors == 0 && tracker.expected_corr.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule

// File: filelist.f
rtl/pcs_pkg.sv
rtl/pcs_engine.sv
rtl/pearson_correlation_stream.sv
tb/testbench.sv
